[rtl/core/fixed_radius_neighbor_search_unit_assert.svh]
// Assertion macros used by the port checker of the neighbor search unit.
`ifndef FIXED_RADIUS_NEIGHBOR_SEARCH_UNIT_ASSERT_SVH
`define FIXED_RADIUS_NEIGHBOR_SEARCH_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define FRN_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frn assertion failed");

// Next-cycle implication, checked outside reset.
`define FRN_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frn assertion failed");

`endif

[rtl/core/frn_pkg.sv]
// Types, constants and helper functions of the neighbor search unit.
package frn_pkg;

  localparam int MAX_PARTICLES = 2048;
  localparam int MAX_NEIGHBORS = 60;
  localparam int SLOT_W = $clog2(MAX_PARTICLES);
  localparam int CNT_W = SLOT_W + 1;
  localparam int NBR_W = 6;
  localparam int POS_W = 24;
  localparam int CELL_W = 21;
  localparam int INV_W = 24;
  localparam int RAD_W = 52;
  localparam int SQ_W = 50;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 52;
  localparam int CELL_SHIFT = 28;

  typedef logic signed [POS_W-1:0] pos_t;
  typedef logic signed [CELL_W-1:0] cell_t;

  typedef struct packed {
    pos_t x;
    pos_t y;
    pos_t z;
  } vec_pos_t;

  typedef struct packed {
    cell_t x;
    cell_t y;
    cell_t z;
  } vec_cell_t;

  typedef struct packed {
    logic      valid;
    vec_pos_t  pos;
    vec_cell_t grid;
  } entry_t;

  typedef struct packed {
    logic slot_valid;
    logic cell_match;
    logic in_radius;
  } dist_res_t;

  typedef enum logic [1:0] {
    OP_CLEAR    = 2'd0,
    OP_FLUID    = 2'd1,
    OP_BOUNDARY = 2'd2,
    OP_QUERY    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_NOT_LOADED = 2'd1,
    STAT_FULL       = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_NUM_FLUID     = 2'd0,
    REG_INV_CELL_SIZE = 2'd1,
    REG_RADIUS_SQ     = 2'd2,
    REG_MAX_NEIGHBORS = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_QWAIT,
    ST_RD,
    ST_LAT,
    ST_CHK,
    ST_FLUSH
  } state_t;

  // Cell coordinate: floor of position times inverse cell size.
  function automatic cell_t cell_of(pos_t p, logic [INV_W-1:0] inv);
    logic signed [POS_W+INV_W:0] prod;
    prod = p * $signed({1'b0, inv});
    return prod[POS_W+INV_W -: CELL_W];
  endfunction

endpackage

[rtl/core/frn_if.sv]
// Handshake channels of the neighbor search unit.
interface frn_req_if;
  logic                    valid;
  logic                    ready;
  logic [1:0]              opcode;
  frn_pkg::pos_t           pos_x;
  frn_pkg::pos_t           pos_y;
  frn_pkg::pos_t           pos_z;
  logic [frn_pkg::SLOT_W-1:0] query_index;
  modport source (output valid, opcode, pos_x, pos_y, pos_z, query_index, input ready);
  modport sink (input valid, opcode, pos_x, pos_y, pos_z, query_index, output ready);
endinterface

interface frn_rsp_if;
  logic                    valid;
  logic                    ready;
  logic [frn_pkg::SLOT_W-1:0] neighbor_index;
  logic                    has_neighbor;
  logic [frn_pkg::NBR_W-1:0]  neighbor_count;
  logic [1:0]              status;
  logic                    last;
  modport source (output valid, neighbor_index, has_neighbor, neighbor_count, status, last,
                  input ready);
  modport sink (input valid, neighbor_index, has_neighbor, neighbor_count, status, last,
                output ready);
endinterface

interface frn_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [frn_pkg::CFG_IDX_W-1:0]  reg_index;
  logic [frn_pkg::CFG_DATA_W-1:0] wdata;
  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface

[rtl/core/frn_store.sv]
// Particle store: one synchronous single-port memory of positions and cells.
module frn_store (
  input  logic                        clk,
  input  logic                        we,
  input  logic [frn_pkg::SLOT_W-1:0]  addr,
  input  frn_pkg::entry_t             wdata,
  output frn_pkg::entry_t             rdata
);
  import frn_pkg::*;

  entry_t mem [MAX_PARTICLES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[rtl/core/frn_dist.sv]
// Distance unit: registered squared differences and cell test, then the radius test.
module frn_dist (
  input  logic                       clk,
  input  logic                       en,
  input  frn_pkg::vec_pos_t          qpos,
  input  frn_pkg::vec_cell_t         qcell,
  input  logic [1:0]                 ox,
  input  logic [1:0]                 oy,
  input  logic [1:0]                 oz,
  input  frn_pkg::entry_t            cand,
  input  logic [frn_pkg::RAD_W-1:0]  radius_sq,
  output frn_pkg::dist_res_t         res
);
  import frn_pkg::*;

  logic signed [POS_W:0]  dx, dy, dz;
  logic signed [SQ_W-1:0] px, py, pz;
  logic [SQ_W-1:0]        sq_x, sq_y, sq_z;
  logic                   match, valid;
  logic [RAD_W-1:0]       sum;

  function automatic logic same_cell(cell_t q, logic [1:0] o, cell_t c);
    logic [1:0]        off;
    logic [CELL_W:0]   tgt;
    off = o - 2'd1;
    tgt = {q[CELL_W-1], q} + {{(CELL_W-1){off[1]}}, off};
    return tgt == {c[CELL_W-1], c};
  endfunction

  always_comb begin
    dx = qpos.x - cand.pos.x;
    dy = qpos.y - cand.pos.y;
    dz = qpos.z - cand.pos.z;
    px = dx * dx;
    py = dy * dy;
    pz = dz * dz;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_x  <= unsigned'(px);
      sq_y  <= unsigned'(py);
      sq_z  <= unsigned'(pz);
      valid <= cand.valid;
      match <= same_cell(qcell.x, ox, cand.grid.x) && same_cell(qcell.y, oy, cand.grid.y) &&
               same_cell(qcell.z, oz, cand.grid.z);
    end
  end

  always_comb begin
    sum = {2'b00, sq_x} + {2'b00, sq_y} + {2'b00, sq_z};
    res.slot_valid = valid;
    res.cell_match = match;
    res.in_radius  = sum < radius_sq;
  end

endmodule

[rtl/core/fixed_radius_neighbor_search_unit.sv]
// Top level of the fixed-radius neighbor search unit.
// Clear and load items give their one result in the cycle after acceptance.
// A clear then sweeps the store, writing every slot, before the next item is taken.
// A query scans the slots below H, H being the highest loaded slot plus one, in up to
// 27 cell passes over the store's single read port, each slot through RD, LAT and CHK.
// Synchronous reset restores the control and config registers and runs the same sweep.
module fixed_radius_neighbor_search_unit (
  input logic       clk,
  input logic       rst,
  frn_req_if.sink   req,
  frn_rsp_if.source rsp,
  frn_cfg_if.sink   cfg
);
  import frn_pkg::*;

  logic [CNT_W-1:0]  num_fluid;
  logic [INV_W-1:0]  inv_cell_size;
  logic [RAD_W-1:0]  radius_sq;
  logic [NBR_W-1:0]  max_neighbors;

  state_t            state, state_next;
  logic [SLOT_W-1:0] clr_cnt, clr_cnt_next;
  logic [CNT_W-1:0]  fluid_loaded, fluid_loaded_next;
  logic [CNT_W-1:0]  boundary_loaded, boundary_loaded_next;
  logic [CNT_W-1:0]  hi, hi_next;
  logic [SLOT_W-1:0] scan, scan_next;
  logic [SLOT_W-1:0] qi, qi_next;
  logic [1:0]        ox, ox_next, oy, oy_next, oz, oz_next;
  logic [NBR_W-1:0]  cnt, cnt_next, cap, cap_next;
  logic              pend_v, pend_v_next;
  logic [SLOT_W-1:0] pend_idx, pend_idx_next;
  vec_pos_t          qpos, qpos_next;
  vec_cell_t         qcell, qcell_next;

  logic              ov, ov_next;
  logic [SLOT_W-1:0] o_idx, o_idx_next;
  logic              o_has, o_has_next;
  logic [NBR_W-1:0]  o_cnt, o_cnt_next;
  status_t           o_stat, o_stat_next;
  logic              o_last, o_last_next;

  logic              mem_we;
  logic [SLOT_W-1:0] mem_addr;
  entry_t            mem_wdata, mem_rdata, load_entry;
  dist_res_t         dres;

  logic [CNT_W-1:0]  flimit;
  logic [CNT_W:0]    bslot;
  logic [NBR_W-1:0]  cap_cfg;
  logic              out_free, hit, scan_end;

  frn_store u_store (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  frn_dist u_dist (
    .clk       (clk),
    .en        (state == ST_LAT),
    .qpos      (qpos),
    .qcell     (qcell),
    .ox        (ox),
    .oy        (oy),
    .oz        (oz),
    .cand      (mem_rdata),
    .radius_sq (radius_sq),
    .res       (dres)
  );

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_fluid     <= '0;
      inv_cell_size <= INV_W'(65536);
      radius_sq     <= RAD_W'(16777216);
      max_neighbors <= NBR_W'(MAX_NEIGHBORS);
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.reg_index))
        REG_NUM_FLUID:     num_fluid     <= cfg.wdata[CNT_W-1:0];
        REG_INV_CELL_SIZE: inv_cell_size <= cfg.wdata[INV_W-1:0];
        REG_RADIUS_SQ:     radius_sq     <= cfg.wdata[RAD_W-1:0];
        REG_MAX_NEIGHBORS: max_neighbors <= cfg.wdata[NBR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    flimit  = (num_fluid > CNT_W'(MAX_PARTICLES)) ? CNT_W'(MAX_PARTICLES) : num_fluid;
    bslot   = {1'b0, flimit} + {1'b0, boundary_loaded};
    cap_cfg = (max_neighbors > NBR_W'(MAX_NEIGHBORS)) ? NBR_W'(MAX_NEIGHBORS) : max_neighbors;
    load_entry.valid  = 1'b1;
    load_entry.pos.x  = req.pos_x;
    load_entry.pos.y  = req.pos_y;
    load_entry.pos.z  = req.pos_z;
    load_entry.grid.x = cell_of(req.pos_x, inv_cell_size);
    load_entry.grid.y = cell_of(req.pos_y, inv_cell_size);
    load_entry.grid.z = cell_of(req.pos_z, inv_cell_size);
    out_free = !ov || rsp.ready;
    hit      = dres.slot_valid && dres.cell_match && dres.in_radius && (scan != qi);
    scan_end = (CNT_W'(scan) + CNT_W'(1)) == hi;
  end

  always_comb begin
    state_next           = state;
    clr_cnt_next         = clr_cnt;
    fluid_loaded_next    = fluid_loaded;
    boundary_loaded_next = boundary_loaded;
    hi_next              = hi;
    scan_next            = scan;
    qi_next              = qi;
    ox_next              = ox;
    oy_next              = oy;
    oz_next              = oz;
    cnt_next             = cnt;
    cap_next             = cap;
    pend_v_next          = pend_v;
    pend_idx_next        = pend_idx;
    qpos_next            = qpos;
    qcell_next           = qcell;
    ov_next              = ov && !rsp.ready;
    o_idx_next           = o_idx;
    o_has_next           = o_has;
    o_cnt_next           = o_cnt;
    o_stat_next          = o_stat;
    o_last_next          = o_last;
    mem_we               = 1'b0;
    mem_addr             = scan;
    mem_wdata            = '0;
    req.ready            = 1'b0;

    case (state)
      ST_INIT: begin
        mem_we       = 1'b1;
        mem_addr     = clr_cnt;
        clr_cnt_next = clr_cnt + SLOT_W'(1);
        if (clr_cnt == SLOT_W'(MAX_PARTICLES - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        req.ready = out_free;
        if (req.valid && out_free) begin
          ov_next     = 1'b1;
          o_idx_next  = '0;
          o_has_next  = 1'b0;
          o_cnt_next  = '0;
          o_stat_next = STAT_OK;
          o_last_next = 1'b1;
          case (op_t'(req.opcode))
            OP_CLEAR: begin
              fluid_loaded_next    = '0;
              boundary_loaded_next = '0;
              hi_next              = '0;
              clr_cnt_next         = '0;
              state_next           = ST_INIT;
            end
            OP_FLUID: begin
              if (fluid_loaded >= flimit) begin
                o_stat_next = STAT_FULL;
              end else begin
                mem_we            = 1'b1;
                mem_addr          = fluid_loaded[SLOT_W-1:0];
                mem_wdata         = load_entry;
                fluid_loaded_next = fluid_loaded + CNT_W'(1);
                if (fluid_loaded + CNT_W'(1) > hi) begin
                  hi_next = fluid_loaded + CNT_W'(1);
                end
              end
            end
            OP_BOUNDARY: begin
              if (bslot >= (CNT_W+1)'(MAX_PARTICLES)) begin
                o_stat_next = STAT_FULL;
              end else begin
                mem_we               = 1'b1;
                mem_addr             = bslot[SLOT_W-1:0];
                mem_wdata            = load_entry;
                boundary_loaded_next = boundary_loaded + CNT_W'(1);
                if (bslot[CNT_W-1:0] + CNT_W'(1) > hi) begin
                  hi_next = bslot[CNT_W-1:0] + CNT_W'(1);
                end
              end
            end
            OP_QUERY: begin
              if ({1'b0, req.query_index} >= fluid_loaded) begin
                o_stat_next = STAT_NOT_LOADED;
              end else begin
                ov_next     = 1'b0;
                mem_addr    = req.query_index;
                qi_next     = req.query_index;
                cnt_next    = '0;
                cap_next    = cap_cfg;
                pend_v_next = 1'b0;
                state_next  = ST_QWAIT;
              end
            end
            default: ;
          endcase
        end
      end
      ST_QWAIT: begin
        qpos_next  = mem_rdata.pos;
        qcell_next = mem_rdata.grid;
        scan_next  = '0;
        ox_next    = '0;
        oy_next    = '0;
        oz_next    = '0;
        state_next = (cap == '0) ? ST_FLUSH : ST_RD;
      end
      ST_RD: begin
        state_next = ST_LAT;
      end
      ST_LAT: begin
        state_next = ST_CHK;
      end
      ST_CHK: begin
        if (!(hit && pend_v && !out_free)) begin
          if (hit) begin
            if (pend_v) begin
              ov_next     = 1'b1;
              o_idx_next  = pend_idx;
              o_has_next  = 1'b1;
              o_cnt_next  = cnt;
              o_stat_next = STAT_OK;
              o_last_next = 1'b0;
            end
            pend_v_next   = 1'b1;
            pend_idx_next = scan;
            cnt_next      = cnt + NBR_W'(1);
          end
          if (hit && (cnt + NBR_W'(1) == cap)) begin
            state_next = ST_FLUSH;
          end else if (scan_end) begin
            scan_next  = '0;
            state_next = ST_RD;
            if (oz != 2'd2) begin
              oz_next = oz + 2'd1;
            end else begin
              oz_next = '0;
              if (oy != 2'd2) begin
                oy_next = oy + 2'd1;
              end else begin
                oy_next = '0;
                if (ox != 2'd2) begin
                  ox_next = ox + 2'd1;
                end else begin
                  state_next = ST_FLUSH;
                end
              end
            end
          end else begin
            scan_next  = scan + SLOT_W'(1);
            state_next = ST_RD;
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          ov_next     = 1'b1;
          o_idx_next  = pend_v ? pend_idx : '0;
          o_has_next  = pend_v;
          o_cnt_next  = pend_v ? cnt : '0;
          o_stat_next = STAT_OK;
          o_last_next = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_INIT;
      clr_cnt         <= '0;
      fluid_loaded    <= '0;
      boundary_loaded <= '0;
      hi              <= '0;
      pend_v          <= 1'b0;
      ov              <= 1'b0;
    end else begin
      state           <= state_next;
      clr_cnt         <= clr_cnt_next;
      fluid_loaded    <= fluid_loaded_next;
      boundary_loaded <= boundary_loaded_next;
      hi              <= hi_next;
      pend_v          <= pend_v_next;
      ov              <= ov_next;
    end
    scan     <= scan_next;
    qi       <= qi_next;
    ox       <= ox_next;
    oy       <= oy_next;
    oz       <= oz_next;
    cnt      <= cnt_next;
    cap      <= cap_next;
    pend_idx <= pend_idx_next;
    qpos     <= qpos_next;
    qcell    <= qcell_next;
    o_idx    <= o_idx_next;
    o_has    <= o_has_next;
    o_cnt    <= o_cnt_next;
    o_stat   <= o_stat_next;
    o_last   <= o_last_next;
  end

  assign rsp.valid          = ov;
  assign rsp.neighbor_index = o_idx;
  assign rsp.has_neighbor   = o_has;
  assign rsp.neighbor_count = o_cnt;
  assign rsp.status         = o_stat;
  assign rsp.last           = o_last;

endmodule

[rtl/core/frn_chk.sv]
// Port checker of the neighbor search unit and its bind statement.
`include "fixed_radius_neighbor_search_unit_assert.svh"

module frn_chk (
  input logic                       clk,
  input logic                       rst,
  input logic                       rsp_valid,
  input logic                       rsp_ready,
  input logic                       has_neighbor,
  input logic [frn_pkg::NBR_W-1:0]  neighbor_count,
  input logic [1:0]                 status,
  input logic                       last
);
  import frn_pkg::*;

  `FRN_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
  `FRN_ASSERT_NOW(a_empty_shape, rsp_valid && !has_neighbor, neighbor_count == '0 && last)
  `FRN_ASSERT_NOW(a_hit_shape, rsp_valid && has_neighbor, status == STAT_OK && neighbor_count != '0)
  `FRN_ASSERT_NOW(a_error_alone, rsp_valid && status != STAT_OK, last && !has_neighbor)

endmodule

bind fixed_radius_neighbor_search_unit frn_chk u_frn_chk (
  .clk            (clk),
  .rst            (rst),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .has_neighbor   (rsp.has_neighbor),
  .neighbor_count (rsp.neighbor_count),
  .status         (rsp.status),
  .last           (rsp.last)
);

[verif/tb.sv]
// Self-checking testbench for the fixed-radius neighbor search unit.
module tb;
  import frn_pkg::*;

  typedef struct {
    op_t                 op;
    pos_t                x;
    pos_t                y;
    pos_t                z;
    logic [SLOT_W-1:0]   qi;
  } search_req_t;

  typedef struct {
    logic [SLOT_W-1:0] idx;
    logic              has;
    logic [NBR_W-1:0]  cnt;
    status_t           st;
    logic              last;
  } nbr_result_t;

  logic clk;
  logic rst;

  frn_req_if req_ch ();
  frn_rsp_if rsp_ch ();
  frn_cfg_if cfg_ch ();

  fixed_radius_neighbor_search_unit uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch)
  );

  search_req_t pending[$];
  nbr_result_t expected_results[$];

  logic [11:0] m_num_fluid;
  logic [23:0] m_inv_cell;
  logic [51:0] m_radius_sq;
  logic [5:0]  m_max_nbr;
  longint      m_pos[MAX_PARTICLES][3];
  longint      m_cell[MAX_PARTICLES][3];
  bit          m_used[MAX_PARTICLES];
  int          m_fluid_cnt = 0;
  int          m_bnd_cnt = 0;

  int  mismatches = 0;
  int  items_sent = 0;
  int  results_seen = 0;
  int  queries_sent = 0;
  bit  no_idle;
  bit  want_hold;
  int  hold_cnt;
  int  gap_cnt;
  int  stall_cnt;

  function automatic longint cell_coord(pos_t p, logic [23:0] inv);
    longint prod;
    prod = longint'(p) * longint'({1'b0, inv});
    return prod >>> CELL_SHIFT;
  endfunction

  function automatic int fluid_limit();
    return (m_num_fluid < MAX_PARTICLES) ? int'(m_num_fluid) : MAX_PARTICLES;
  endfunction

  function automatic nbr_result_t mk_result(logic [SLOT_W-1:0] idx, logic has,
                                            logic [NBR_W-1:0] cnt, status_t st,
                                            logic last);
    nbr_result_t r;
    r.idx = idx;
    r.has = has;
    r.cnt = cnt;
    r.st = st;
    r.last = last;
    return r;
  endfunction

  task automatic add_expect(nbr_result_t r);
    expected_results.insert(expected_results.size(), r);
  endtask

  task automatic store_particle(int slot, search_req_t it);
    m_pos[slot][0] = longint'(it.x);
    m_pos[slot][1] = longint'(it.y);
    m_pos[slot][2] = longint'(it.z);
    m_cell[slot][0] = cell_coord(it.x, m_inv_cell);
    m_cell[slot][1] = cell_coord(it.y, m_inv_cell);
    m_cell[slot][2] = cell_coord(it.z, m_inv_cell);
    m_used[slot] = 1;
  endtask

  task automatic predict_search(search_req_t it);
    int qi;
    int slot;
    int cap;
    int found;
    longint d;
    longint unsigned d2;
    case (it.op)
      OP_CLEAR: begin
        foreach (m_used[i]) m_used[i] = 0;
        m_fluid_cnt = 0;
        m_bnd_cnt = 0;
        add_expect(mk_result('0, 1'b0, '0, STAT_OK, 1'b1));
      end
      OP_FLUID: begin
        if (m_fluid_cnt >= fluid_limit()) begin
          add_expect(mk_result('0, 1'b0, '0, STAT_FULL, 1'b1));
        end else begin
          store_particle(m_fluid_cnt, it);
          m_fluid_cnt++;
          add_expect(mk_result('0, 1'b0, '0, STAT_OK, 1'b1));
        end
      end
      OP_BOUNDARY: begin
        slot = fluid_limit() + m_bnd_cnt;
        if (slot >= MAX_PARTICLES) begin
          add_expect(mk_result('0, 1'b0, '0, STAT_FULL, 1'b1));
        end else begin
          store_particle(slot, it);
          m_bnd_cnt++;
          add_expect(mk_result('0, 1'b0, '0, STAT_OK, 1'b1));
        end
      end
      default: begin
        qi = int'(it.qi);
        if (qi >= m_fluid_cnt || !m_used[qi]) begin
          add_expect(mk_result('0, 1'b0, '0, STAT_NOT_LOADED, 1'b1));
        end else begin
          cap = (m_max_nbr > MAX_NEIGHBORS) ? MAX_NEIGHBORS : int'(m_max_nbr);
          found = 0;
          for (int dx = -1; dx <= 1; dx++)
            for (int dy = -1; dy <= 1; dy++)
              for (int dz = -1; dz <= 1; dz++)
                for (int s = 0; s < MAX_PARTICLES; s++) begin
                  if (m_used[s] && s != qi && m_cell[s][0] == m_cell[qi][0] + dx &&
                      m_cell[s][1] == m_cell[qi][1] + dy &&
                      m_cell[s][2] == m_cell[qi][2] + dz) begin
                    d2 = 0;
                    for (int a = 0; a < 3; a++) begin
                      d = m_pos[qi][a] - m_pos[s][a];
                      d2 += longint'(d * d);
                    end
                    if (d2 < longint'(m_radius_sq) && found < cap) begin
                      add_expect(mk_result(SLOT_W'(s), 1'b1, NBR_W'(found + 1), STAT_OK,
                                           1'b0));
                      found++;
                    end
                  end
                end
          if (found == 0)
            add_expect(mk_result('0, 1'b0, '0, STAT_OK, 1'b1));
          else
            expected_results[expected_results.size() - 1].last = 1;
        end
      end
    endcase
  endtask

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Sender: one item at a time from the pending queue, with a random gap between items unless no_idle is set.
  always @(posedge clk) begin
    search_req_t it;
    logic nxt_valid;
    if (rst) begin
      req_ch.valid <= 0;
      req_ch.opcode <= OP_CLEAR;
      req_ch.pos_x <= '0;
      req_ch.pos_y <= '0;
      req_ch.pos_z <= '0;
      req_ch.query_index <= '0;
      gap_cnt <= 0;
    end else begin
      nxt_valid = req_ch.valid;
      if (req_ch.valid && req_ch.ready) begin
        it.op = op_t'(req_ch.opcode);
        it.x = req_ch.pos_x;
        it.y = req_ch.pos_y;
        it.z = req_ch.pos_z;
        it.qi = req_ch.query_index;
        predict_search(it);
        items_sent++;
        if (it.op == OP_QUERY) queries_sent++;
        nxt_valid = 0;
      end
      if (!nxt_valid) begin
        if (gap_cnt > 0) begin
          gap_cnt <= gap_cnt - 1;
        end else if (pending.size() > 0) begin
          it = pending.pop_front();
          req_ch.opcode <= it.op;
          req_ch.pos_x <= it.x;
          req_ch.pos_y <= it.y;
          req_ch.pos_z <= it.z;
          req_ch.query_index <= it.qi;
          nxt_valid = 1;
          gap_cnt <= no_idle ? 0 : (($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0);
        end
      end
      req_ch.valid <= nxt_valid;
    end
  end

  // Receiver: random stalls, plus one long hold-off when requested.
  always @(posedge clk) begin
    nbr_result_t e;
    logic nxt_ready;
    if (rst) begin
      rsp_ch.ready <= 0;
      stall_cnt <= 0;
      hold_cnt <= 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("tb: unexpected result idx=%0d has=%0d cnt=%0d st=%0d last=%0d",
                     rsp_ch.neighbor_index, rsp_ch.has_neighbor, rsp_ch.neighbor_count,
                     rsp_ch.status, rsp_ch.last);
        end else begin
          e = expected_results.pop_front();
          if (rsp_ch.neighbor_index !== e.idx || rsp_ch.has_neighbor !== e.has ||
              rsp_ch.neighbor_count !== e.cnt || rsp_ch.status !== e.st ||
              rsp_ch.last !== e.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("tb: mismatch exp %0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d",
                       e.idx, e.has, e.cnt, e.st, e.last, rsp_ch.neighbor_index,
                       rsp_ch.has_neighbor, rsp_ch.neighbor_count, rsp_ch.status,
                       rsp_ch.last);
          end
        end
      end
      if (want_hold && hold_cnt < 400) begin
        hold_cnt <= hold_cnt + 1;
        nxt_ready = 0;
      end else if (stall_cnt > 0) begin
        stall_cnt <= stall_cnt - 1;
        nxt_ready = 0;
      end else begin
        nxt_ready = 1;
        if (rsp_ch.valid && rsp_ch.ready && !no_idle && $urandom_range(0, 2) == 0)
          stall_cnt <= $urandom_range(0, 19);
      end
      rsp_ch.ready <= nxt_ready;
    end
  end

  task automatic cfg_write(cfg_reg_t r, logic [51:0] v);
    @(posedge clk);
    cfg_ch.valid <= 1;
    cfg_ch.reg_index <= r;
    cfg_ch.wdata <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 0;
    case (r)
      REG_NUM_FLUID:     m_num_fluid = v[11:0];
      REG_INV_CELL_SIZE: m_inv_cell = v[23:0];
      REG_RADIUS_SQ:     m_radius_sq = v;
      REG_MAX_NEIGHBORS: m_max_nbr = v[5:0];
      default: ;
    endcase
  endtask

  task automatic push_item(op_t op, longint x, longint y, longint z, int qi);
    search_req_t it;
    it.op = op;
    it.x = pos_t'(x);
    it.y = pos_t'(y);
    it.z = pos_t'(z);
    it.qi = qi[SLOT_W-1:0];
    pending.insert(pending.size(), it);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (pending.size() != 0 || req_ch.valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic longint near_pos(longint c, longint span);
    longint v;
    v = c + longint'($urandom_range(0, int'(span))) - span / 2;
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return v;
  endfunction

  task automatic random_frame(int phase);
    int nf;
    int nb;
    int nq;
    longint cell_len;
    longint span;
    longint r;
    longint cx;
    longint cy;
    longint cz;
    logic [23:0] inv;
    case ($urandom_range(0, 3))
      0: inv = 24'd65536;
      1: inv = 24'd16384;
      2: inv = 24'd262144;
      default: inv = 24'($urandom_range(4096, 1048576));
    endcase
    cell_len = (longint'(1) << 28) / inv;
    span = 3 * cell_len;
    if (span > 4000000) span = 4000000;
    r = cell_len * $urandom_range(50, 150) / 100;
    nf = $urandom_range(4, 16);
    nb = $urandom_range(0, 8);
    nq = $urandom_range(8, 14);
    cfg_write(REG_NUM_FLUID, 52'(nf));
    cfg_write(REG_INV_CELL_SIZE, 52'(inv));
    cfg_write(REG_RADIUS_SQ, 52'(r * r));
    cfg_write(REG_MAX_NEIGHBORS, 52'((phase == 3) ? 3 : $urandom_range(1, 60)));
    cx = $signed($urandom_range(0, 16000000)) - 8000000;
    cy = $signed($urandom_range(0, 16000000)) - 8000000;
    cz = $signed($urandom_range(0, 16000000)) - 8000000;
    if (phase != 2) push_item(OP_CLEAR, 0, 0, 0, 0);
    for (int i = 0; i < nf; i++)
      push_item(OP_FLUID, near_pos(cx, span), near_pos(cy, span), near_pos(cz, span),
                $urandom());
    push_item(OP_FLUID, $urandom(), $urandom(), $urandom(), $urandom());
    for (int i = 0; i < nb; i++)
      if ($urandom_range(0, 4) == 0)
        push_item(OP_BOUNDARY, $urandom(), $urandom(), $urandom(), $urandom());
      else
        push_item(OP_BOUNDARY, near_pos(cx, span), near_pos(cy, span), near_pos(cz, span),
                  $urandom());
    for (int i = 0; i < nq; i++)
      push_item(OP_QUERY, $urandom(), $urandom(), $urandom(),
                ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2047) :
                $urandom_range(0, nf + 1));
  endtask

  initial begin
    rst = 1;
    no_idle = 0;
    want_hold = 0;
    cfg_ch.valid = 0;
    cfg_ch.reg_index = REG_NUM_FLUID;
    cfg_ch.wdata = '0;
    m_num_fluid = 0;
    m_inv_cell = 24'd65536;
    m_radius_sq = 52'd16777216;
    m_max_nbr = 6'd60;
    repeat (11) @(posedge clk);
    rst <= 0;

    // Reset defaults: no fluid slots, so fluid loads are dropped.
    push_item(OP_QUERY, 0, 0, 0, 0);
    push_item(OP_FLUID, 0, 0, 0, 0);
    push_item(OP_BOUNDARY, 0, 0, 0, 0);
    push_item(OP_CLEAR, 0, 0, 0, 0);
    wait_idle();

    cfg_write(REG_NUM_FLUID, 52'd6);
    cfg_write(REG_RADIUS_SQ, 52'(longint'(4) << 24));
    push_item(OP_FLUID, 0, 0, 0, 0);
    push_item(OP_FLUID, 2048, 0, 0, 0);
    push_item(OP_FLUID, 8388607, 8388607, 8388607, 0);
    push_item(OP_FLUID, -8388608, -8388608, -8388608, 0);
    push_item(OP_FLUID, -4096, 4095, -1, 0);
    push_item(OP_FLUID, 8388606, 8388600, 8388607, 0);
    push_item(OP_FLUID, 1, 1, 1, 0);
    push_item(OP_BOUNDARY, 4096, 4096, 4096, 0);
    push_item(OP_BOUNDARY, -1, -1, -1, 0);
    for (int q = 0; q < 6; q++) push_item(OP_QUERY, 0, 0, 0, q);
    push_item(OP_QUERY, 0, 0, 0, 2047);
    wait_idle();

    // Caps of one, zero and above the limit, widest radius, finest and coarsest cells, zero radius.
    cfg_write(REG_MAX_NEIGHBORS, 52'd1);
    cfg_write(REG_RADIUS_SQ, 52'hF_FFFF_FFFF_FFFF);
    push_item(OP_QUERY, 0, 0, 0, 0);
    wait_idle();
    cfg_write(REG_MAX_NEIGHBORS, 52'd0);
    push_item(OP_QUERY, 0, 0, 0, 0);
    wait_idle();
    cfg_write(REG_MAX_NEIGHBORS, 52'd63);
    cfg_write(REG_INV_CELL_SIZE, 52'hFF_FFFF);
    push_item(OP_QUERY, 0, 0, 0, 4);
    wait_idle();
    cfg_write(REG_INV_CELL_SIZE, 52'd1);
    cfg_write(REG_RADIUS_SQ, 52'd0);
    push_item(OP_CLEAR, 0, 0, 0, 0);
    push_item(OP_FLUID, 5, 5, 5, 0);
    push_item(OP_FLUID, 5, 5, 5, 0);
    push_item(OP_QUERY, 0, 0, 0, 0);
    wait_idle();

    // Fluid region covers the whole store, so boundary loads are dropped.
    cfg_write(REG_NUM_FLUID, 52'd4095);
    push_item(OP_BOUNDARY, 0, 0, 0, 0);
    wait_idle();
    cfg_write(REG_NUM_FLUID, 52'd2048);
    push_item(OP_BOUNDARY, 0, 0, 0, 0);
    push_item(OP_FLUID, 0, 0, 0, 0);
    wait_idle();

    for (int p = 0; p < 4; p++) begin
      no_idle = (p == 1);
      random_frame(p);
      if (p == 2) want_hold = 1;
      wait_idle();
    end
    no_idle = 0;

    wait_idle();
    repeat (100) @(posedge clk);
    $display("tb: %0d items (%0d queries) sent, %0d results checked, %0d mismatches",
             items_sent, queries_sent, results_seen, mismatches);
    $display("tb: covered all opcodes, dropped loads, unloaded queries, caps and config extremes");
    if (mismatches == 0 && expected_results.size() == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

  initial begin
    #30000000;
    $display("tb: timeout");
    $display("tb: done, errors");
    $finish;
  end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/frn_pkg.sv
rtl/core/frn_if.sv
rtl/core/frn_store.sv
rtl/core/frn_dist.sv
rtl/core/fixed_radius_neighbor_search_unit.sv
rtl/core/frn_chk.sv
verif/tb.sv
